// ===== rtl/swab_pkg.sv =====
`default_nettype none
package swab_pkg;

  localparam int MaxPayload = 63;
  localparam int StoreAw    = 6;

  localparam logic [1:0] ActPayload = 2'd0;
  localparam logic [1:0] ActFrame   = 2'd1;
  localparam logic [1:0] ActTick    = 2'd2;

  localparam logic [2:0] KindStatus  = 3'd0;
  localparam logic [2:0] KindTx      = 3'd1;
  localparam logic [2:0] KindDeliver = 3'd2;
  localparam logic [2:0] KindDone    = 3'd3;
  localparam logic [2:0] KindReject  = 3'd4;

  localparam logic [1:0] LinkIdle    = 2'd0;
  localparam logic [1:0] LinkWaitAck = 2'd1;
  localparam logic [1:0] LinkSuccess = 2'd2;
  localparam logic [1:0] LinkRetry   = 2'd3;

  localparam logic [2:0] RegMinPay  = 3'd0;
  localparam logic [2:0] RegBoMin   = 3'd1;
  localparam logic [2:0] RegBoMax   = 3'd2;
  localparam logic [2:0] RegTimeout = 3'd3;
  localparam logic [2:0] RegSeed    = 3'd4;

  typedef struct packed {
    logic        start;
    logic [16:0] dividend;
    logic [13:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [13:0] rem;
  } div_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/swab_mod.sv =====
`default_nettype none
module swab_mod (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire swab_pkg::div_req_t req_i,
  output swab_pkg::div_rsp_t      rsp_o
);
  import swab_pkg::*;

  logic [16:0] num_q, num_d;
  logic [13:0] den_q, den_d;
  logic [14:0] rem_q, rem_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [14:0] trial;
  logic [15:0] diff;

  always_comb begin
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[13:0], num_q[16]};
    diff   = {1'b0, trial} - {2'b0, den_q};
    if (req_i.start) begin
      num_d  = req_i.dividend;
      den_d  = req_i.divisor;
      rem_d  = '0;
      cnt_d  = 5'd17;
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[15:0], 1'b0};
      rem_d = diff[15] ? trial : diff[14:0];
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q[13:0];

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("done held");
  a_busy_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("done while busy");
  a_rem_lt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> ({1'b0, rem_q[13:0]} < {1'b0, den_q})) else $error("rem too large");

endmodule
`default_nettype wire

// ===== rtl/stop_and_wait_arq_backoff_unit.sv =====
`default_nettype none
// Channel  Dir  Handshake                Payload
// input    in   in_valid_i/in_stall_o    action_i data_byte_i in_last_i
// result   out  out_valid_o/out_stall_i  out_kind_o out_byte_o frame_end_o run_last_o
//                                        link_state_o
// config   in   psel/penable/pready      paddr pwdata prdata
// A transaction that yields one result passes through StIdle and StExec; an ACK behind a delivered byte adds StEmit.
// A frame send pads one zero byte a cycle, writes the header into store address 0, then emits
// each stored byte through StRead and StSend; a resend emits the stored bytes the same way.
// A retry draw starts the divider, runs its 17 modulo steps and then loads the backoff.
// A stalled result holds the sequencer until it is taken.
// Reset loads the register defaults; the resend store is not cleared.
module stop_and_wait_arq_backoff_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  action_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        in_last_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       out_kind_o,
  output logic [7:0]       out_byte_o,
  output logic             frame_end_o,
  output logic             run_last_o,
  output logic [1:0]       link_state_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import swab_pkg::*;

  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StExec  = 7'b0000010,
    StPad   = 7'b0000100,
    StDiv   = 7'b0001000,
    StSend  = 7'b0010000,
    StRead  = 7'b0100000,
    StEmit  = 7'b1000000
  } seq_e;

  seq_e sq_q;
  logic [5:0]  minp_q;
  logic [12:0] bmin_q, bmax_q, tmo_q;
  logic [15:0] seed_q, rnd_q;
  logic [1:0]  link_q;
  logic        sseq_q, rseq_q;
  logic [6:0]  rlen_q;
  logic [12:0] boc_q, toc_q;
  logic [3:0]  rxf_q;
  logic [1:0]  act_q;
  logic [7:0]  byte_q;
  logic        last_q;
  logic [6:0]  idx_q;
  logic [7:0]  store [64];
  logic [7:0]  rd_q;
  logic        ack_q;
  logic        ov_q;
  logic [2:0]  ok_q;
  logic [7:0]  ob_q;
  logic        oe_q, orl_q;
  logic [1:0]  ol_q;
  logic        dreq_start_q;
  div_req_t    dreq;
  div_rsp_t    drsp;

  logic cfg_wr, out_free;
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign out_free = !ov_q || !out_stall_i;
  assign in_stall_o = (sq_q != StIdle);

  swab_mod u_mod (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  always_comb begin
    case (paddr[4:2])
      RegMinPay:  prdata = {26'd0, minp_q};
      RegBoMin:   prdata = {19'd0, bmin_q};
      RegBoMax:   prdata = {19'd0, bmax_q};
      RegTimeout: prdata = {19'd0, tmo_q};
      RegSeed:    prdata = {16'd0, seed_q};
      default:    prdata = '0;
    endcase
  end

  logic [15:0] rnd_next;
  assign rnd_next = rnd_q[0] ? ((rnd_q >> 1) ^ 16'hB400) : (rnd_q >> 1);
  logic [5:0] minp_eff;
  assign minp_eff = (minp_q > 6'(MaxPayload)) ? 6'(MaxPayload) : minp_q;
  logic [12:0] tlim;
  assign tlim = (tmo_q == '0) ? 13'd1 : tmo_q;
  logic [12:0] toc_inc;
  assign toc_inc = toc_q + 13'd1;
  logic [6:0] rlen_inc;
  assign rlen_inc = rlen_q + 7'd1;

  always_comb begin
    dreq.start    = dreq_start_q;
    dreq.dividend = {1'b0, rnd_next};
    dreq.divisor  = {1'b0, bmax_q} - {1'b0, bmin_q} + 14'd1;
  end

  logic       st_we;
  logic [5:0] st_wa;
  logic [7:0] st_wd;

  always_comb begin
    st_we = 1'b0;
    st_wa = rlen_inc[5:0];
    st_wd = '0;
    case (sq_q)
      StExec: begin
        if (out_free && (act_q == ActPayload) && (link_q == LinkIdle)) begin
          st_we = 1'b1;
          st_wd = byte_q;
        end
      end
      StPad: begin
        st_we = 1'b1;
        if (rlen_q >= {1'b0, minp_eff}) begin
          st_wa = '0;
          st_wd = {7'd0, sseq_q};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (st_we) store[st_wa] <= st_wd;
    if (sq_q == StRead) rd_q <= store[idx_q[5:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_q   <= StIdle;
      minp_q <= 6'd8;
      bmin_q <= 13'd2000;
      bmax_q <= 13'd6000;
      tmo_q  <= 13'd5000;
      seed_q <= 16'd44257;
      rnd_q  <= 16'd44257;
      link_q <= LinkIdle;
      sseq_q <= 1'b0;
      rseq_q <= 1'b1;
      rlen_q <= '0;
      boc_q  <= '0;
      toc_q  <= '0;
      rxf_q  <= '0;
      ov_q   <= 1'b0;
      act_q  <= '0;
      byte_q <= '0;
      last_q <= 1'b0;
      idx_q  <= '0;
      ack_q  <= 1'b0;
      dreq_start_q <= 1'b0;
      ok_q <= '0; ob_q <= '0; oe_q <= 1'b0; orl_q <= 1'b0; ol_q <= '0;
    end else begin
      if (ov_q && !out_stall_i) ov_q <= 1'b0;
      if (cfg_wr) begin
        case (paddr[4:2])
          RegMinPay:  minp_q <= pwdata[5:0];
          RegBoMin:   bmin_q <= pwdata[12:0];
          RegBoMax:   bmax_q <= pwdata[12:0];
          RegTimeout: tmo_q  <= pwdata[12:0];
          RegSeed: begin
            seed_q <= pwdata[15:0];
            rnd_q  <= (pwdata[15:0] == '0) ? 16'd1 : pwdata[15:0];
          end
          default: ;
        endcase
      end
      case (sq_q)
        StIdle: begin
          if (in_valid_i) begin
            act_q <= action_i; byte_q <= data_byte_i; last_q <= in_last_i;
            sq_q <= StExec;
          end
        end
        StExec: begin
          if (out_free) begin
            sq_q <= StIdle;
            ov_q <= 1'b1; ok_q <= KindStatus; ob_q <= '0; oe_q <= 1'b0; orl_q <= 1'b1;
            ol_q <= link_q;
            case (act_q)
              ActPayload: begin
                if (link_q != LinkIdle) ok_q <= KindReject;
                else begin
                  rlen_q <= rlen_inc;
                  if (last_q || rlen_inc >= 7'(MaxPayload)) begin
                    ov_q <= 1'b0;
                    sq_q <= StPad;
                  end
                end
              end
              ActFrame: begin
                if (!rxf_q[0]) begin
                  rxf_q <= {byte_q[0], !byte_q[1] && (byte_q[0] != rseq_q), !byte_q[1], 1'b1};
                  if (last_q) begin
                    rxf_q <= '0;
                    if (!byte_q[1]) begin
                      ok_q <= KindTx; ob_q <= {6'd0, 1'b1, byte_q[0]}; oe_q <= 1'b1;
                      if (byte_q[0] != rseq_q) rseq_q <= byte_q[0];
                    end else if (link_q == LinkWaitAck) begin
                      if (byte_q[0] == sseq_q) begin
                        sseq_q <= !sseq_q; link_q <= LinkSuccess; ol_q <= LinkSuccess;
                        boc_q <= bmax_q; ok_q <= KindDone;
                      end else begin
                        ov_q <= 1'b0; sq_q <= StDiv; dreq_start_q <= 1'b1;
                      end
                    end
                  end
                end else begin
                  if (rxf_q[2:1] == 2'b11) begin
                    ok_q <= KindDeliver; ob_q <= byte_q; oe_q <= last_q;
                    orl_q <= !last_q;
                  end
                  if (last_q) begin
                    rxf_q <= '0;
                    if (rxf_q[1]) begin
                      if (rxf_q[2]) begin
                        rseq_q <= rxf_q[3];
                        ov_q <= (rxf_q[2:1] == 2'b11) ? 1'b1 : 1'b0;
                        ack_q <= 1'b1; sq_q <= StEmit;
                        if (rxf_q[2:1] != 2'b11) ov_q <= 1'b0;
                      end else begin
                        ok_q <= KindTx; ob_q <= {6'd0, 1'b1, rxf_q[3]}; oe_q <= 1'b1;
                        orl_q <= 1'b1;
                      end
                    end else if (link_q == LinkWaitAck) begin
                      if (rxf_q[3] == sseq_q) begin
                        sseq_q <= !sseq_q; link_q <= LinkSuccess; ol_q <= LinkSuccess;
                        boc_q <= bmax_q; ok_q <= KindDone;
                      end else begin
                        ov_q <= 1'b0; sq_q <= StDiv; dreq_start_q <= 1'b1;
                      end
                    end
                  end
                end
              end
              ActTick: begin
                if (link_q == LinkWaitAck) begin
                  toc_q <= toc_inc;
                  if (toc_inc >= tlim) begin
                    ov_q <= 1'b0; sq_q <= StDiv; dreq_start_q <= 1'b1;
                  end
                end else if (link_q[1]) begin
                  if (boc_q > 13'd1) boc_q <= boc_q - 13'd1;
                  else begin
                    boc_q <= '0;
                    if (link_q == LinkSuccess) begin
                      link_q <= LinkIdle; ol_q <= LinkIdle; rlen_q <= '0;
                    end else begin
                      ov_q <= 1'b0; idx_q <= '0; sq_q <= StRead;
                    end
                  end
                end
              end
              default: ;
            endcase
          end
        end
        StPad: begin
          if (rlen_q < {1'b0, minp_eff}) begin
            rlen_q <= rlen_inc;
          end else begin
            rlen_q <= rlen_inc;
            idx_q <= '0;
            sq_q <= StRead;
          end
        end
        StDiv: begin
          dreq_start_q <= 1'b0;
          if (dreq_start_q) rnd_q <= rnd_next;
          if (drsp.done) begin
            link_q <= LinkRetry;
            boc_q <= (bmax_q < bmin_q) ? bmin_q : bmin_q + drsp.rem[12:0];
            if (out_free) begin
              ov_q <= 1'b1; ok_q <= KindStatus; ob_q <= '0; oe_q <= 1'b0; orl_q <= 1'b1;
              ol_q <= LinkRetry; sq_q <= StIdle;
            end else begin
              sq_q <= StEmit;
            end
          end
        end
        StRead: begin
          link_q <= LinkWaitAck; toc_q <= '0;
          sq_q <= StSend;
        end
        StSend: begin
          if (out_free) begin
            ov_q <= 1'b1; ok_q <= KindTx; ob_q <= rd_q;
            oe_q <= (idx_q + 7'd1 == rlen_q); orl_q <= (idx_q + 7'd1 == rlen_q);
            ol_q <= LinkWaitAck;
            idx_q <= idx_q + 7'd1;
            sq_q <= (idx_q + 7'd1 == rlen_q) ? StIdle : StRead;
          end
        end
        StEmit: begin
          if (out_free) begin
            ov_q <= 1'b1; ol_q <= link_q; orl_q <= 1'b1;
            if (ack_q) begin
              ok_q <= KindTx; ob_q <= {6'd0, 1'b1, rseq_q}; oe_q <= 1'b1;
            end else begin
              ok_q <= KindStatus; ob_q <= '0; oe_q <= 1'b0;
            end
            ack_q <= 1'b0;
            sq_q <= StIdle;
          end
        end
        default: sq_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o  = ov_q;
  assign out_kind_o   = ok_q;
  assign out_byte_o   = ob_q;
  assign frame_end_o  = oe_q;
  assign run_last_o   = orl_q;
  assign link_state_o = ol_q;

endmodule
`default_nettype wire
